### rtl/core/spq_pkg.sv
// Package for the sorted priority queue: payload types, codes and defaults.
`default_nettype none
package spq_pkg;

	// Default capacity of the queue
	localparam int SPQ_DEPTH = 16;

	// Action codes
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	// Status codes
	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_DELETED  = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	// Command transfer
	typedef struct packed {
		logic               action;
		logic signed [15:0] item_value;
		logic [7:0]         item_priority;
	} cmd_t;

	// Result transfer
	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] head_value;
		logic [7:0]         head_priority;
		logic [4:0]         occupancy;
	} rsp_t;

	// One stored queue entry
	typedef struct packed {
		logic signed [15:0] value;
		logic [7:0]         prio;
	} entry_t;

	// Per-cycle operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} ctrl_t;

endpackage
`default_nettype wire

### rtl/core/spq_cell.sv
// One position of the sorted queue: holds an entry and shifts with its neighbors.
`default_nettype none
module spq_cell (
	input  wire logic            clk,
	input  wire spq_pkg::ctrl_t  ctrl,
	input  wire spq_pkg::entry_t new_entry,
	input  wire spq_pkg::entry_t left_entry,
	input  wire spq_pkg::entry_t right_entry,
	input  wire logic            left_after,
	input  wire logic            occupied,
	output spq_pkg::entry_t      entry,
	output logic                 after
);
	import spq_pkg::*;

	entry_t entry_q;

	// New entry belongs at or before this position (ties stay behind)
	assign after = !occupied || (entry_q.prio > new_entry.prio);
	assign entry = entry_q;

	// Insert: shift right from the insertion point; delete: shift left
	always_ff @(posedge clk) begin
		if (ctrl.ins && after) begin
			entry_q <= left_after ? left_entry : new_entry;
		end else if (ctrl.del) begin
			entry_q <= right_entry;
		end
	end

endmodule
`default_nettype wire

### rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: row of cells, entry count and result register.
`default_nettype none
// Sorted priority queue of QUEUE_DEPTH entries. A command is taken on any cycle with
// start high (busy is always low), one command per clock. Its result appears with
// done high in the next cycle and must be captured then; there is no stall.
// Every cell compares its priority with the incoming one in parallel and the whole row
// shifts in the same cycle. No clearing pass is needed after reset: only positions below
// the entry count are ever read.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::SPQ_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire spq_pkg::cmd_t cmd,
	output logic               done,
	output spq_pkg::rsp_t      rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             done_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic             accept;
	logic             full;
	logic             empty;
	ctrl_t            ctrl;
	entry_t           new_entry;
	entry_t           ent [QUEUE_DEPTH];
	logic             aft [QUEUE_DEPTH];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);

	// Operation decode
	assign ctrl.ins = accept && (cmd.action == ACT_INSERT) && !full;
	assign ctrl.del = accept && (cmd.action == ACT_DELETE) && !empty;
	assign new_entry.value = cmd.item_value;
	assign new_entry.prio  = cmd.item_priority;

	// Row of cells
	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_a;

		if (g == 0) begin : g_first
			assign left_e = new_entry;
			assign left_a = 1'b0;
		end else begin : g_mid
			assign left_e = ent[g-1];
			assign left_a = aft[g-1];
		end

		if (g == QUEUE_DEPTH - 1) begin : g_last
			assign right_e = new_entry;
		end else begin : g_inner
			assign right_e = ent[g+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.left_entry (left_e),
			.right_entry(right_e),
			.left_after (left_a),
			.occupied   (CNT_W'(g) < count_q),
			.entry      (ent[g]),
			.after      (aft[g])
		);
	end

	// Next count and result
	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.del) begin
			count_d = count_q - CNT_W'(1);
		end

		rsp_d.head_value    = '0;
		rsp_d.head_priority = '0;
		rsp_d.occupancy     = 5'(count_d);
		if (cmd.action == ACT_INSERT) begin
			rsp_d.status = full ? ST_FULL : ST_INSERTED;
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.status        = ST_DELETED;
			rsp_d.head_value    = ent[0].value;
			rsp_d.head_priority = ent[0].prio;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			done_q  <= accept;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above capacity");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command produced no result");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result without a command");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.del |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("delete did not decrement count");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (ent[0].prio <= ent[1].prio))
		else $error("head entry out of priority order");
`endif

endmodule
`default_nettype wire
